// ===== hdl/lpg_pkg.sv =====
// Shared types, widths and helpers for the line pixel generator.
// No dependencies; every other file in hdl/ imports this package.
package lpg_pkg;

    localparam int LPG_CB       = 16;
    localparam int LPG_STEP_W   = 12;
    localparam int LPG_COLOUR_W = 24;
    localparam int LPG_OFS_W    = 25;
    localparam int LPG_DIM_W    = 13;
    localparam int LPG_PITCH_W  = 14;
    localparam int LPG_CFG_IDX_W = 2;

    localparam int LPG_EW = (LPG_CB > LPG_STEP_W) ? LPG_CB : LPG_STEP_W;
    localparam int LPG_QW = LPG_EW;
    localparam int LPG_NW = LPG_CB + LPG_EW;
    localparam int LPG_WW = LPG_EW + 3;
    localparam int LPG_PROD_W = LPG_DIM_W + LPG_PITCH_W;

    typedef enum logic [LPG_CFG_IDX_W-1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_PITCH
    } t_cfg_reg;

    typedef struct packed {
        logic signed [LPG_CB-1:0]  start_x;
        logic signed [LPG_CB-1:0]  start_y;
        logic signed [LPG_CB-1:0]  end_x;
        logic signed [LPG_CB-1:0]  end_y;
        logic [LPG_COLOUR_W-1:0]   pixel_colour;
        logic [LPG_STEP_W-1:0]     step_index;
    } t_lpg_in;

    typedef struct packed {
        logic signed [LPG_CB-1:0]  pixel_x;
        logic signed [LPG_CB-1:0]  pixel_y;
        logic [LPG_OFS_W-1:0]      word_offset;
        logic [LPG_COLOUR_W-1:0]   colour_out;
        logic                      write_pixel;
        logic                      final_step;
    } t_lpg_out;

    typedef struct packed {
        logic [LPG_DIM_W-1:0]   width;
        logic [LPG_DIM_W-1:0]   height;
        logic [LPG_PITCH_W-1:0] pitch;
    } t_lpg_cfg;

    // per-item context carried alongside the divider
    typedef struct packed {
        logic                      xmaj;
        logic                      pre_ok;
        logic                      last;
        logic                      q_neg;
        logic                      da_zero;
        logic signed [LPG_CB-1:0]  b1;
        logic signed [LPG_WW-1:0]  major;
        logic [LPG_COLOUR_W-1:0]   colour;
    } t_lpg_side;

    function automatic logic signed [LPG_WW-1:0] lpg_dim_ext(input logic [LPG_DIM_W-1:0] v);
        return $signed(LPG_WW'(v));
    endfunction

endpackage

// ===== hdl/line_pixel_generator_core.sv =====
// Line pixel generator top level: config registers, skid, setup, divider, post.
// Depends on lpg_pkg, lpg_skid, lpg_setup, lpg_div and lpg_post.
//
// While the output is not stalled, takes one request and returns one pixel per
// clock; pixels come back one per request, in order, through 4 setup stages,
// a 16-stage divider that resolves one quotient bit per stage, and 4 output
// stages ending in the output register. A stall on the output freezes the
// whole pipeline; the input side sees it in the next cycle through a one-entry
// skid register, so one extra request is still taken. Canvas width and height
// above min(CANVAS_MAX, 8191) are clamped to it. Configuration writes are
// always ready and should only be issued with no requests in flight.
module line_pixel_generator_core import lpg_pkg::*; #(
    parameter int CANVAS_MAX = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_lpg_in                   i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_lpg_out                  o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [LPG_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LPG_PITCH_W-1:0]    i_cfg_data
);

    localparam int DIM_MAX  = (1 << LPG_DIM_W) - 1;
    localparam int DIM_CLIP = (CANVAS_MAX > DIM_MAX) ? DIM_MAX : CANVAS_MAX;
    localparam logic [LPG_DIM_W-1:0]   DIM_LIMIT   = LPG_DIM_W'(DIM_CLIP);
    localparam logic [LPG_DIM_W-1:0]   WIDTH_RST   = LPG_DIM_W'(800);
    localparam logic [LPG_DIM_W-1:0]   HEIGHT_RST  = LPG_DIM_W'(600);
    localparam logic [LPG_PITCH_W-1:0] PITCH_RST   = LPG_PITCH_W'(800);

    logic [LPG_DIM_W-1:0]   r_cfg_width;
    logic [LPG_DIM_W-1:0]   r_cfg_height;
    logic [LPG_PITCH_W-1:0] r_cfg_pitch;
    t_lpg_cfg               w_cfg;

    logic                   w_adv;
    logic                   w_skid_valid;
    t_lpg_in                w_skid_data;
    logic                   w_setup_valid;
    logic [LPG_NW-1:0]      w_num;
    logic [LPG_CB-1:0]      w_den;
    t_lpg_side              w_setup_side;
    logic                   w_div_valid;
    logic [LPG_QW-1:0]      w_quo;
    t_lpg_side              w_div_side;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_cfg_pitch  <= PITCH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_WIDTH: begin
                    r_cfg_width <= i_cfg_data[LPG_DIM_W-1:0];
                end
                REG_HEIGHT: begin
                    r_cfg_height <= i_cfg_data[LPG_DIM_W-1:0];
                end
                REG_PITCH: begin
                    r_cfg_pitch <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.width  = (r_cfg_width  > DIM_LIMIT) ? DIM_LIMIT : r_cfg_width;
    assign w_cfg.height = (r_cfg_height > DIM_LIMIT) ? DIM_LIMIT : r_cfg_height;
    assign w_cfg.pitch  = r_cfg_pitch;

    assign w_adv = !(o_out_valid && i_out_stall);

    lpg_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_adv   (w_adv),
        .o_valid (w_skid_valid),
        .o_data  (w_skid_data)
    );

    lpg_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_skid_valid),
        .i_req   (w_skid_data),
        .i_cfg   (w_cfg),
        .o_valid (w_setup_valid),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_side  (w_setup_side)
    );

    lpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_setup_valid),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_setup_side),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_side  (w_div_side)
    );

    lpg_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_div_valid),
        .i_quo   (w_quo),
        .i_side  (w_div_side),
        .i_cfg   (w_cfg),
        .o_valid (o_out_valid),
        .o_rsp   (o_out_data)
    );

    a_no_write_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_pixel |-> o_out_data.word_offset == '0)
        else $error("offset nonzero on a pixel that is not written");

    a_write_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_pixel
            |-> !o_out_data.pixel_x[LPG_CB-1] && !o_out_data.pixel_y[LPG_CB-1])
        else $error("written pixel has a negative coordinate");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid) && $past(i_out_stall))
        else $error("skid filled without a request held off by an output stall");

endmodule

// ===== hdl/lpg_skid.sv =====
// Input skid register for the line pixel generator request channel.
// Depends on lpg_pkg for the request type.
module lpg_skid import lpg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_lpg_in i_data,
    input  logic    i_adv,
    output logic    o_valid,
    output t_lpg_in o_data
);

    logic    r_full;
    t_lpg_in r_buf;

    assign o_stall = r_full;
    assign o_valid = r_full | i_valid;
    assign o_data  = r_full ? r_buf : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (r_full) begin
            if (i_adv) begin
                r_full <= 1'b0;
            end
        end else if (i_valid && !i_adv) begin
            r_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_full && i_valid && !i_adv) begin
            r_buf <= i_data;
        end
    end

endmodule

// ===== hdl/lpg_setup.sv =====
// Front stages: deltas, major-axis pick, span and offset magnitude,
// canvas pre-checks, then the |d_minor| * |offset| product. Uses lpg_pkg.
module lpg_setup import lpg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  t_lpg_in             i_req,
    input  t_lpg_cfg            i_cfg,
    output logic                o_valid,
    output logic [LPG_NW-1:0]   o_num,
    output logic [LPG_CB-1:0]   o_den,
    output t_lpg_side           o_side
);

    // stage 1
    logic                     r1_v;
    t_lpg_in                  r1_req;
    logic signed [LPG_CB:0]   r1_dx;
    logic signed [LPG_CB:0]   r1_dy;
    logic signed [LPG_CB:0]   n1_dx;
    logic signed [LPG_CB:0]   n1_dy;

    // stage 2
    logic                     r2_v;
    logic                     r2_xmaj;
    logic                     r2_neg_da;
    logic                     r2_db_neg;
    logic [LPG_CB-1:0]        r2_span;
    logic [LPG_CB-1:0]        r2_adb;
    logic signed [LPG_CB-1:0] r2_lo;
    logic signed [LPG_CB-1:0] r2_hi;
    logic signed [LPG_CB-1:0] r2_b0;
    logic signed [LPG_CB-1:0] r2_b1;
    logic [LPG_STEP_W-1:0]    r2_step;
    logic [LPG_COLOUR_W-1:0]  r2_colour;
    logic [LPG_CB-1:0]        w_adx;
    logic [LPG_CB-1:0]        w_ady;
    logic                     n2_xmaj;
    logic                     n2_neg_da;

    // stage 3
    logic                     r3_v;
    logic [LPG_CB-1:0]        r3_adb;
    logic [LPG_EW-1:0]        r3_ae;
    logic [LPG_CB-1:0]        r3_span;
    t_lpg_side                r3_side;
    logic [LPG_EW-1:0]        w_step_e;
    logic [LPG_EW-1:0]        w_span_e;
    logic                     w_span_gt;
    logic                     w_e_neg;
    logic [LPG_DIM_W-1:0]     w_amax;
    logic [LPG_DIM_W-1:0]     w_bmax;
    logic signed [LPG_WW-1:0] w_lo;
    logic signed [LPG_WW-1:0] w_hi;
    logic signed [LPG_WW-1:0] w_b0;
    logic [LPG_EW-1:0]        n3_ae;
    t_lpg_side                n3_side;

    // stage 4
    logic                     r4_v;
    logic [LPG_NW-1:0]        r4_num;
    logic [LPG_CB-1:0]        r4_den;
    t_lpg_side                r4_side;

    // stage 1: deltas
    assign n1_dx = (LPG_CB+1)'(i_req.end_x) - (LPG_CB+1)'(i_req.start_x);
    assign n1_dy = (LPG_CB+1)'(i_req.end_y) - (LPG_CB+1)'(i_req.start_y);

    // stage 2: axis selection
    assign w_adx     = LPG_CB'(r1_dx[LPG_CB] ? -r1_dx : r1_dx);
    assign w_ady     = LPG_CB'(r1_dy[LPG_CB] ? -r1_dy : r1_dy);
    assign n2_xmaj   = w_adx > w_ady;
    assign n2_neg_da = n2_xmaj ? r1_dx[LPG_CB] : r1_dy[LPG_CB];

    // stage 3: offset from first endpoint, pre-checks
    assign w_step_e  = LPG_EW'(r2_step);
    assign w_span_e  = LPG_EW'(r2_span);
    assign w_span_gt = w_span_e > w_step_e;
    assign w_e_neg   = r2_neg_da && w_span_gt;
    assign w_amax    = r2_xmaj ? i_cfg.width  : i_cfg.height;
    assign w_bmax    = r2_xmaj ? i_cfg.height : i_cfg.width;
    assign w_lo      = LPG_WW'(r2_lo);
    assign w_hi      = LPG_WW'(r2_hi);
    assign w_b0      = LPG_WW'(r2_b0);

    always_comb begin
        if (!r2_neg_da) begin
            n3_ae = w_step_e;
        end else if (w_span_gt) begin
            n3_ae = w_span_e - w_step_e;
        end else begin
            n3_ae = w_step_e - w_span_e;
        end
        n3_side.xmaj    = r2_xmaj;
        n3_side.pre_ok  = !w_lo[LPG_WW-1] && (w_hi < lpg_dim_ext(w_amax))
                          && (w_step_e <= w_span_e)
                          && !w_b0[LPG_WW-1] && (w_b0 < lpg_dim_ext(w_bmax));
        n3_side.last    = w_step_e == w_span_e;
        n3_side.q_neg   = r2_db_neg ^ w_e_neg ^ r2_neg_da;
        n3_side.da_zero = r2_span == '0;
        n3_side.b1      = r2_b1;
        n3_side.major   = w_lo + $signed(LPG_WW'(r2_step));
        n3_side.colour  = r2_colour;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_req    <= i_req;
            r1_dx     <= n1_dx;
            r1_dy     <= n1_dy;

            r2_xmaj   <= n2_xmaj;
            r2_neg_da <= n2_neg_da;
            r2_db_neg <= n2_xmaj ? r1_dy[LPG_CB] : r1_dx[LPG_CB];
            r2_span   <= n2_xmaj ? w_adx : w_ady;
            r2_adb    <= n2_xmaj ? w_ady : w_adx;
            if (n2_xmaj) begin
                r2_lo <= n2_neg_da ? r1_req.end_x   : r1_req.start_x;
                r2_hi <= n2_neg_da ? r1_req.start_x : r1_req.end_x;
                r2_b0 <= n2_neg_da ? r1_req.end_y   : r1_req.start_y;
                r2_b1 <= r1_req.start_y;
            end else begin
                r2_lo <= n2_neg_da ? r1_req.end_y   : r1_req.start_y;
                r2_hi <= n2_neg_da ? r1_req.start_y : r1_req.end_y;
                r2_b0 <= n2_neg_da ? r1_req.end_x   : r1_req.start_x;
                r2_b1 <= r1_req.start_x;
            end
            r2_step   <= r1_req.step_index;
            r2_colour <= r1_req.pixel_colour;

            r3_adb    <= r2_adb;
            r3_ae     <= n3_ae;
            r3_span   <= r2_span;
            r3_side   <= n3_side;

            r4_num    <= LPG_NW'(r3_adb) * LPG_NW'(r3_ae);
            r4_den    <= r3_span;
            r4_side   <= r3_side;
        end
    end

    assign o_valid = r4_v;
    assign o_num   = r4_num;
    assign o_den   = r4_den;
    assign o_side  = r4_side;

endmodule

// ===== hdl/lpg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, magnitudes only.
// Item context rides along in t_lpg_side. Uses lpg_pkg.
module lpg_div import lpg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [LPG_NW-1:0]   i_num,
    input  logic [LPG_CB-1:0]   i_den,
    input  t_lpg_side           i_side,
    output logic                o_valid,
    output logic [LPG_QW-1:0]   o_quo,
    output t_lpg_side           o_side
);

    localparam int STAGES = LPG_QW;

    logic [STAGES-1:0]   r_v;
    logic [LPG_NW-1:0]   r_rem  [STAGES-1];
    logic [LPG_CB-1:0]   r_den  [STAGES-1];
    logic [LPG_QW-1:0]   r_quo  [STAGES];
    t_lpg_side           r_side [STAGES];

    logic [LPG_NW-1:0]   w_rem_in [STAGES];
    logic [LPG_CB-1:0]   w_den_in [STAGES];
    logic [LPG_QW-1:0]   w_quo_in [STAGES];
    logic [LPG_NW:0]     w_trial  [STAGES];
    logic [LPG_NW-1:0]   n_rem    [STAGES-1];
    logic [LPG_QW-1:0]   n_quo    [STAGES];

    always_comb begin
        w_rem_in[0] = i_num;
        w_den_in[0] = i_den;
        w_quo_in[0] = '0;
        for (int k = 1; k < STAGES; k++) begin
            w_rem_in[k] = r_rem[k-1];
            w_den_in[k] = r_den[k-1];
            w_quo_in[k] = r_quo[k-1];
        end
        for (int k = 0; k < STAGES; k++) begin
            w_trial[k] = {1'b0, w_rem_in[k]}
                         - ((LPG_NW+1)'(w_den_in[k]) << (STAGES - 1 - k));
            n_quo[k]   = {w_quo_in[k][LPG_QW-2:0], !w_trial[k][LPG_NW]};
        end
        for (int k = 0; k < STAGES - 1; k++) begin
            n_rem[k] = w_trial[k][LPG_NW] ? w_rem_in[k] : w_trial[k][LPG_NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int k = 1; k < STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < STAGES; k++) begin
                r_quo[k] <= n_quo[k];
            end
            for (int k = 0; k < STAGES - 1; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= w_den_in[k];
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

// ===== hdl/lpg_post.sv =====
// Back stages: signed minor coordinate, final canvas check, row offset
// multiply, offset add and the output register. Uses lpg_pkg.
module lpg_post import lpg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [LPG_QW-1:0]   i_quo,
    input  t_lpg_side           i_side,
    input  t_lpg_cfg            i_cfg,
    output logic                o_valid,
    output t_lpg_out            o_rsp
);

    // stage 1
    logic                     r1_v;
    logic signed [LPG_WW-1:0] r1_bs;
    t_lpg_side                r1_side;
    logic signed [LPG_WW-1:0] w_b1;
    logic signed [LPG_WW-1:0] w_q;
    logic signed [LPG_WW-1:0] n1_bs;

    // stage 2
    logic                     r2_v;
    logic signed [LPG_WW-1:0] r2_px;
    logic signed [LPG_WW-1:0] r2_py;
    logic                     r2_write;
    logic                     r2_last;
    logic [LPG_COLOUR_W-1:0]  r2_colour;
    logic [LPG_DIM_W-1:0]     w_bmax;
    logic                     n2_write;

    // stage 3
    logic                     r3_v;
    logic [LPG_PROD_W-1:0]    r3_prod;
    logic signed [LPG_WW-1:0] r3_px;
    logic signed [LPG_WW-1:0] r3_py;
    logic                     r3_write;
    logic                     r3_last;
    logic [LPG_COLOUR_W-1:0]  r3_colour;

    // stage 4 (output)
    logic                     r4_v;
    t_lpg_out                 r4_rsp;
    logic [LPG_PROD_W-1:0]    w_sum;

    assign w_b1  = LPG_WW'(i_side.b1);
    assign w_q   = $signed(LPG_WW'(i_quo));

    always_comb begin
        if (i_side.da_zero) begin
            n1_bs = w_b1;
        end else if (i_side.q_neg) begin
            n1_bs = w_b1 - w_q;
        end else begin
            n1_bs = w_b1 + w_q;
        end
    end

    assign w_bmax   = r1_side.xmaj ? i_cfg.height : i_cfg.width;
    assign n2_write = r1_side.pre_ok && !r1_bs[LPG_WW-1] && (r1_bs < lpg_dim_ext(w_bmax));

    assign w_sum = LPG_PROD_W'(r3_px[LPG_DIM_W-1:0]) + r3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_bs     <= n1_bs;
            r1_side   <= i_side;

            r2_px     <= r1_side.xmaj ? r1_side.major : r1_bs;
            r2_py     <= r1_side.xmaj ? r1_bs : r1_side.major;
            r2_write  <= n2_write;
            r2_last   <= r1_side.last;
            r2_colour <= r1_side.colour;

            r3_prod   <= LPG_PROD_W'(r2_py[LPG_DIM_W-1:0]) * LPG_PROD_W'(i_cfg.pitch);
            r3_px     <= r2_px;
            r3_py     <= r2_py;
            r3_write  <= r2_write;
            r3_last   <= r2_last;
            r3_colour <= r2_colour;

            r4_rsp.pixel_x     <= r3_px[LPG_CB-1:0];
            r4_rsp.pixel_y     <= r3_py[LPG_CB-1:0];
            r4_rsp.word_offset <= r3_write ? w_sum[LPG_OFS_W-1:0] : '0;
            r4_rsp.colour_out  <= r3_colour;
            r4_rsp.write_pixel <= r3_write;
            r4_rsp.final_step  <= r3_last;
        end
    end

    assign o_valid = r4_v;
    assign o_rsp   = r4_rsp;

endmodule

// ===== bench/tb_line_pixel_generator_core.sv =====
`timescale 1ns / 100ps
// Self-checking bench for line_pixel_generator_core: line requests in, pixels out.
// Depends on lpg_pkg and the core; predicts each pixel and checks it in order.
module tb_line_pixel_generator_core;
    import lpg_pkg::*;

    localparam int CANVAS_LIMIT = 4096;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 200;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_lpg_in                  i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_lpg_out                 o_out_data;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [LPG_CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LPG_PITCH_W-1:0]   i_cfg_data = '0;

    logic [LPG_DIM_W-1:0]   canvas_w = 13'd800;
    logic [LPG_DIM_W-1:0]   canvas_h = 13'd600;
    logic [LPG_PITCH_W-1:0] row_pitch = 14'd800;

    t_lpg_in  lines_to_send[$];
    t_lpg_out pixels_due[$];
    int       errors = 0;
    int       burst_left = 1;
    int       gap_left = 0;
    int       hold_left = 0;
    int       since_hold = 2000;
    int       stall_mode = 0;
    int       mode_left = 0;
    int       quiet_cycles = 0;

    line_pixel_generator_core #(.CANVAS_MAX(CANVAS_LIMIT)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_lpg_out rasterize_step(t_lpg_in req);
        longint sx, sy, ex, ey, dx, dy, cw, ch, step;
        longint a1, a2, b1, da, db, amax, bmax, lo, hi, span, m, b0, bs, px, py;
        bit xmaj, wr;
        t_lpg_out r;
        sx = $signed(req.start_x);
        sy = $signed(req.start_y);
        ex = $signed(req.end_x);
        ey = $signed(req.end_y);
        step = req.step_index;
        dx = ex - sx;
        dy = ey - sy;
        cw = (canvas_w > CANVAS_LIMIT) ? CANVAS_LIMIT : longint'(canvas_w);
        ch = (canvas_h > CANVAS_LIMIT) ? CANVAS_LIMIT : longint'(canvas_h);
        xmaj = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
        if (xmaj) begin
            a1 = sx; a2 = ex; b1 = sy; da = dx; db = dy; amax = cw; bmax = ch;
        end else begin
            a1 = sy; a2 = ey; b1 = sx; da = dy; db = dx; amax = ch; bmax = cw;
        end
        lo = (a1 < a2) ? a1 : a2;
        hi = (a1 < a2) ? a2 : a1;
        span = hi - lo;
        m = lo + step;
        // integer division truncates toward zero; zero-length line keeps start_x
        b0 = (da == 0) ? b1 : b1 + (db * (lo - a1)) / da;
        bs = (da == 0) ? b1 : b1 + (db * (m - a1)) / da;
        wr = lo >= 0 && hi < amax && step <= span &&
             b0 >= 0 && b0 < bmax && bs >= 0 && bs < bmax;
        px = xmaj ? m : bs;
        py = xmaj ? bs : m;
        r.pixel_x     = LPG_CB'(px);
        r.pixel_y     = LPG_CB'(py);
        r.word_offset = wr ? LPG_OFS_W'(px + py * longint'(row_pitch)) : '0;
        r.colour_out  = req.pixel_colour;
        r.write_pixel = wr;
        r.final_step  = (step == span);
        return r;
    endfunction

    function automatic int pick_coord(int lim, bit edgy);
        if (edgy) begin
            case ($urandom_range(0, 3))
                0: return -1;
                1: return lim;
                2: return lim - 1;
                default: return 0;
            endcase
        end
        return (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
    endfunction

    function automatic t_lpg_in random_line();
        t_lpg_in r;
        int cw, ch, sel, x0, y0, x1, y1, span, st;
        bit edgy;
        r.pixel_colour = LPG_COLOUR_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            r.start_x = LPG_CB'($urandom);
            r.start_y = LPG_CB'($urandom);
            r.end_x = LPG_CB'($urandom);
            r.end_y = LPG_CB'($urandom);
            r.step_index = LPG_STEP_W'($urandom);
            return r;
        end
        edgy = (sel < 27);
        cw = (canvas_w > CANVAS_LIMIT) ? CANVAS_LIMIT : int'(canvas_w);
        ch = (canvas_h > CANVAS_LIMIT) ? CANVAS_LIMIT : int'(canvas_h);
        x0 = pick_coord(cw, edgy);
        y0 = pick_coord(ch, 1'b0);
        if ($urandom_range(0, 1)) begin
            x1 = x0 + int'($urandom_range(0, 16)) - 8;
            y1 = y0 + int'($urandom_range(0, 16)) - 8;
        end else begin
            x1 = pick_coord(cw, 1'b0);
            y1 = pick_coord(ch, edgy);
        end
        span = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > span)
            span = (y1 > y0) ? y1 - y0 : y0 - y1;
        case ($urandom_range(0, 7))
            0: st = 0;
            1: st = span;
            2: st = span + 1;
            3: st = $urandom_range(0, 4095);
            default: st = $urandom_range(0, span);
        endcase
        if (st > 4095)
            st = $urandom_range(0, 4095);
        r.start_x = LPG_CB'(x0);
        r.start_y = LPG_CB'(y0);
        r.end_x = LPG_CB'(x1);
        r.end_y = LPG_CB'(y1);
        r.step_index = LPG_STEP_W'(st);
        return r;
    endfunction

    task automatic push_line(int sx, int sy, int ex, int ey, int colour, int step);
        t_lpg_in r;
        r.start_x = LPG_CB'(sx);
        r.start_y = LPG_CB'(sy);
        r.end_x = LPG_CB'(ex);
        r.end_y = LPG_CB'(ey);
        r.pixel_colour = LPG_COLOUR_W'(colour);
        r.step_index = LPG_STEP_W'(step);
        lines_to_send.insert(lines_to_send.size(), r);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (lines_to_send.size() != 0 || i_in_valid || pixels_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= LPG_PITCH_W'(val);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH: canvas_w = LPG_DIM_W'(val);
            REG_HEIGHT: canvas_h = LPG_DIM_W'(val);
            default: row_pitch = LPG_PITCH_W'(val);
        endcase
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // request driver: bursts and gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                pixels_due.insert(pixels_due.size(), rasterize_step(i_in_data));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (lines_to_send.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= lines_to_send.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 6);
                            8: gap_left = $urandom_range(7, 20);
                            default: gap_left = $urandom_range(20, 40);
                        endcase
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // pixel receiver stall pattern, with periodic long hold-offs
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (since_hold >= 2500 && i_in_valid) begin
            hold_left = HOLD_CYCLES;
            since_hold = 0;
            i_out_stall <= 1'b1;
        end else begin
            since_hold++;
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                2: i_out_stall <= ($urandom_range(0, 7) == 0);
                default: i_out_stall <= (since_hold % 5 < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_lpg_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixels_due.size() == 0) begin
                $error("pixel with no request outstanding: %h", o_out_data);
                errors++;
            end else begin
                want = pixels_due.pop_front();
                check_field("pixel_x", want.pixel_x, o_out_data.pixel_x);
                check_field("pixel_y", want.pixel_y, o_out_data.pixel_y);
                check_field("word_offset", want.word_offset, o_out_data.word_offset);
                check_field("colour_out", want.colour_out, o_out_data.colour_out);
                check_field("write_pixel", want.write_pixel, o_out_data.write_pixel);
                check_field("final_step", want.final_step, o_out_data.final_step);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int widths[8], heights[8], pitches[8];
        widths  = '{800, 1, 4096, 16383, 0, 640, 37, 800};
        heights = '{600, 1, 4096, 8191, 4096, 0, 4096, 600};
        pitches = '{800, 1, 8192, 16383, 800, 16383, 37, 800};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        push_line(10, 20, 10, 20, 24'h123456, 0);
        push_line(10, 20, 10, 20, 24'h654321, 1);
        push_line(0, 5, 799, 5, 24'hFFFFFF, 799);
        push_line(0, 5, 800, 5, 24'h000001, 3);
        push_line(5, 0, 5, 600, 24'h000002, 3);
        push_line(799, 0, 799, 599, 24'h800000, 599);
        push_line(700, 10, 100, 500, 24'h0F0F0F, 300);
        push_line(500, 10, 100, 590, 24'hF0F0F0, 37);
        push_line(0, 0, 10, 5, 24'hAAAAAA, 4095);
        push_line(0, 0, 10, 5, 24'h555555, 11);
        push_line(-32768, -32768, 32767, 32767, 24'hFFFFFF, 4095);
        push_line(32767, 32767, -32768, -32768, 24'h000000, 0);
        push_line(0, 0, 0, 0, 24'h000000, 0);
        push_line(0, 0, 100, 100, 24'h123ABC, 50);
        push_line(0, -5, 100, 50, 24'h00FF00, 20);
        push_line(799, 599, 0, 0, 24'h0000FF, 799);
        push_line(10, 100, 0, 97, 24'h111111, 4);
        push_line(-1, 3, 20, 4, 24'h222222, 2);
        push_line(3, -1, 4, 20, 24'h333333, 2);
        push_line(400, 300, 400, 301, 24'h444444, 1);
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                drain();
                write_reg(REG_WIDTH, widths[ph]);
                write_reg(REG_HEIGHT, heights[ph]);
                write_reg(REG_PITCH, pitches[ph]);
                @(negedge i_clk);
            end
            repeat (2) begin
                repeat (112) lines_to_send.insert(lines_to_send.size(), random_line());
                drain();
            end
        end
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
